>>> src/mssu_pkg.sv
`default_nettype none
// -----------------------------------------------------------------------------
// mssu_pkg
// Shared types, opcodes and sizes for the integer-subset instruction step unit.
// -----------------------------------------------------------------------------
package mssu_pkg;

	localparam int MEM_WORD_ADDR_BITS_DEF = 18;
	localparam int NUM_REGS               = 16;
	localparam int REG_BITS               = 4;
	localparam int XLEN                   = 32;
	localparam int PC_BITS                = 20;
	localparam int IN_ADDR_BITS           = 18;

	// request kinds
	localparam logic [1:0] REQ_LOAD = 2'd0;
	localparam logic [1:0] REQ_STEP = 2'd1;
	localparam logic [1:0] REQ_READ = 2'd2;

	// primary opcodes
	localparam logic [5:0] OP_SPECIAL = 6'h00;
	localparam logic [5:0] OP_REGIMM  = 6'h01;
	localparam logic [5:0] OP_J       = 6'h02;
	localparam logic [5:0] OP_BEQ     = 6'h04;
	localparam logic [5:0] OP_BNE     = 6'h05;
	localparam logic [5:0] OP_BGTZ    = 6'h07;
	localparam logic [5:0] OP_ADDI    = 6'h08;
	localparam logic [5:0] OP_SLTI    = 6'h0A;
	localparam logic [5:0] OP_ANDI    = 6'h0C;
	localparam logic [5:0] OP_ORI     = 6'h0D;
	localparam logic [5:0] OP_LUI     = 6'h0F;
	localparam logic [5:0] OP_LB      = 6'h20;
	localparam logic [5:0] OP_LW      = 6'h23;
	localparam logic [5:0] OP_SB      = 6'h28;
	localparam logic [5:0] OP_SW      = 6'h2B;

	// function codes of the special opcode
	localparam logic [5:0] FN_SLL  = 6'h00;
	localparam logic [5:0] FN_SRL  = 6'h02;
	localparam logic [5:0] FN_MULT = 6'h18;
	localparam logic [5:0] FN_DIV  = 6'h1A;
	localparam logic [5:0] FN_ADD  = 6'h20;
	localparam logic [5:0] FN_SUB  = 6'h22;
	localparam logic [5:0] FN_AND  = 6'h24;
	localparam logic [5:0] FN_OR   = 6'h25;
	localparam logic [5:0] FN_XOR  = 6'h26;
	localparam logic [5:0] FN_SLT  = 6'h2A;

	localparam logic [4:0] RT_BGEZ = 5'd1;

	localparam logic [REG_BITS-1:0] REG_HI = 4'd10;
	localparam logic [REG_BITS-1:0] REG_LO = 4'd11;

	typedef struct packed {
		logic en;
		logic we;
	} mem_ctl_t;

	typedef struct packed {
		logic                en;
		logic [REG_BITS-1:0] addr;
		logic [XLEN-1:0]     data;
	} rf_wr_t;

	typedef struct packed {
		logic            start;
		logic [XLEN-1:0] dividend;
		logic [XLEN-1:0] divisor;
	} div_req_t;

endpackage
`default_nettype wire

>>> src/mssu_word_mem.sv
`default_nettype none
// -----------------------------------------------------------------------------
// mssu_word_mem
// Single-port word memory, registered read, swept to zero after reset.
// -----------------------------------------------------------------------------
module mssu_word_mem #(
	parameter int AW = mssu_pkg::MEM_WORD_ADDR_BITS_DEF
) (
	input  wire                        clk,
	input  wire                        arst_n,
	input  mssu_pkg::mem_ctl_t         ctl,
	input  wire  [AW-1:0]              addr,
	input  wire  [mssu_pkg::XLEN-1:0]  wdata,
	output logic [mssu_pkg::XLEN-1:0]  rdata,
	output logic                       busy
);
	import mssu_pkg::*;

	logic [XLEN-1:0] mem [2**AW];
	logic [AW-1:0]   clr_cnt_q;
	logic            busy_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_cnt_q <= '0;
			busy_q    <= 1'b1;
		end else if (busy_q) begin
			clr_cnt_q <= clr_cnt_q + 1'b1;
			if (clr_cnt_q == {AW{1'b1}}) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (busy_q) begin
			mem[clr_cnt_q] <= '0;
		end else if (ctl.en && ctl.we) begin
			mem[addr] <= wdata;
		end
		if (ctl.en && !ctl.we) begin
			rdata <= mem[addr];
		end
	end

	assign busy = busy_q;

endmodule
`default_nettype wire

>>> src/mssu_regfile.sv
`default_nettype none
// -----------------------------------------------------------------------------
// mssu_regfile
// Sixteen-word register file, two registered read ports, one write port.
// -----------------------------------------------------------------------------
module mssu_regfile (
	input  wire                            clk,
	input  wire                            arst_n,
	input  wire  [mssu_pkg::REG_BITS-1:0]  ra,
	input  wire  [mssu_pkg::REG_BITS-1:0]  rb,
	output logic [mssu_pkg::XLEN-1:0]      rdata_a,
	output logic [mssu_pkg::XLEN-1:0]      rdata_b,
	input  mssu_pkg::rf_wr_t               wr
);
	import mssu_pkg::*;

	logic [XLEN-1:0]     regs [NUM_REGS];
	logic [NUM_REGS-1:0] valid_q;

	// an entry never written reads as zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (wr.en) begin
			valid_q[wr.addr] <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (wr.en) begin
			regs[wr.addr] <= wr.data;
		end
		rdata_a <= valid_q[ra] ? regs[ra] : '0;
		rdata_b <= valid_q[rb] ? regs[rb] : '0;
	end

endmodule
`default_nettype wire

>>> src/mssu_div.sv
`default_nettype none
// -----------------------------------------------------------------------------
// mssu_div
// Signed 32-bit divider, restoring, one quotient bit per cycle.
// -----------------------------------------------------------------------------
module mssu_div (
	input  wire                        clk,
	input  wire                        arst_n,
	input  mssu_pkg::div_req_t         req,
	output logic                       done,
	output logic [mssu_pkg::XLEN-1:0]  quotient,
	output logic [mssu_pkg::XLEN-1:0]  remainder
);
	import mssu_pkg::*;

	logic [XLEN-1:0] dvd_q, dsr_q, rem_q;
	logic [5:0]      cnt_q;
	logic            run_q, done_q, qneg_q, rneg_q;
	logic [XLEN:0]   trial;

	assign trial = {rem_q, dvd_q[XLEN-1]} - {1'b0, dsr_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				run_q <= 1'b1;
				cnt_q <= 6'(XLEN);
			end else if (run_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == 6'd1) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// quotient bits shift into the dividend register
	always_ff @(posedge clk) begin
		if (req.start) begin
			qneg_q <= req.dividend[XLEN-1] ^ req.divisor[XLEN-1];
			rneg_q <= req.dividend[XLEN-1];
			dvd_q  <= req.dividend[XLEN-1] ? (~req.dividend + 1'b1) : req.dividend;
			dsr_q  <= req.divisor[XLEN-1] ? (~req.divisor + 1'b1) : req.divisor;
			rem_q  <= '0;
		end else if (run_q) begin
			if (!trial[XLEN]) begin
				rem_q <= trial[XLEN-1:0];
				dvd_q <= {dvd_q[XLEN-2:0], 1'b1};
			end else begin
				rem_q <= {rem_q[XLEN-2:0], dvd_q[XLEN-1]};
				dvd_q <= {dvd_q[XLEN-2:0], 1'b0};
			end
		end
	end

	assign done      = done_q;
	assign quotient  = qneg_q ? (~dvd_q + 1'b1) : dvd_q;
	assign remainder = rneg_q ? (~rem_q + 1'b1) : rem_q;

endmodule
`default_nettype wire

>>> src/mips_subset_instruction_step_unit.sv
`default_nettype none
// -----------------------------------------------------------------------------
// mips_subset_instruction_step_unit
// Multicycle interpreter for a small MIPS-like integer subset.
// -----------------------------------------------------------------------------
// One item is worked at a time and each gives one result. After reset the word
// memory is swept to zero with in_stall high. A load goes straight to the result,
// a register read reads the register and then gives the result, and a step runs
// fetch, register read, execute and result; a halting step ends after the fetch.
// lb, lw and sb add a memory state, mult a product write and a div by zero a
// second register write; div waits on the one-bit-per-cycle divider and then makes
// a second register write. A finished result waits in the output register while the next item is taken.
// -----------------------------------------------------------------------------
module mips_subset_instruction_step_unit #(
	parameter int MEM_WORD_ADDR_BITS = mssu_pkg::MEM_WORD_ADDR_BITS_DEF
) (
	input  wire                clk,
	input  wire                arst_n,
	input  wire                in_valid,
	output logic               in_stall,
	input  wire  [1:0]         req_type,
	input  wire  [17:0]        word_addr,
	input  wire  [31:0]        word_data,
	input  wire  [3:0]         reg_select,
	output logic               out_valid,
	input  wire                out_stall,
	output logic [19:0]        pc_now,
	output logic [31:0]        fetched_word,
	output logic signed [31:0] read_value,
	output logic               reg_written,
	output logic [3:0]         dest_reg,
	output logic               halted,
	output logic               illegal_op,
	output logic               divide_by_zero
);
	import mssu_pkg::*;

	localparam int AW = MEM_WORD_ADDR_BITS;

	localparam logic [3:0] ST_IDLE  = 4'd0;
	localparam logic [3:0] ST_RREAD = 4'd1;
	localparam logic [3:0] ST_DEC   = 4'd2;
	localparam logic [3:0] ST_EXE   = 4'd3;
	localparam logic [3:0] ST_MEM   = 4'd4;
	localparam logic [3:0] ST_MUL   = 4'd5;
	localparam logic [3:0] ST_DIV   = 4'd6;
	localparam logic [3:0] ST_WB11  = 4'd7;
	localparam logic [3:0] ST_OUT   = 4'd8;

	logic [3:0]          state_q;
	logic [PC_BITS-1:0]  pc_q;
	logic                halt_q, out_valid_q;
	logic [XLEN-1:0]     ir_q, b_q, r11_q, prod_s1;
	logic [1:0]          lane_q;
	logic [AW-1:0]       widx_q;
	logic [XLEN-1:0]     res_ir_q, res_val_q;
	logic                res_wr_q, res_ill_q, res_dz_q;
	logic [REG_BITS-1:0] res_dst_q;

	mem_ctl_t        mem_ctl;
	logic [AW-1:0]   mem_addr;
	logic [XLEN-1:0] mem_wdata, mem_rdata;
	logic            mem_busy;

	logic [REG_BITS-1:0] rf_ra, rf_rb;
	logic [XLEN-1:0]     rf_a, rf_b;
	rf_wr_t              rf_wr;

	div_req_t        div_req;
	logic            div_done;
	logic [XLEN-1:0] div_q, div_r;

	logic accept;
	assign accept   = in_valid && !in_stall;
	assign in_stall = (state_q != ST_IDLE) || mem_busy;

	// load the output register once the previous result has left
	logic out_load;
	assign out_load = (state_q == ST_OUT) && (!out_valid_q || !out_stall);

	// widen the fixed-width addresses before cutting to the memory size
	logic [AW+17:0] load_ext, fetch_ext;
	logic [AW-1:0]  load_widx, fetch_widx;
	assign load_ext   = {{AW{1'b0}}, word_addr};
	assign fetch_ext  = {{AW{1'b0}}, pc_q[PC_BITS-1:2]};
	assign load_widx  = load_ext[AW-1:0];
	assign fetch_widx = fetch_ext[AW-1:0];

	// decode of the held instruction
	logic [5:0]          op, fn;
	logic [4:0]          sh, rtf;
	logic [REG_BITS-1:0] rt, rd;
	logic [15:0]         imm;
	logic [XLEN-1:0]     simm, ea;
	logic [PC_BITS-1:0]  br_tgt;
	logic [AW-1:0]       ea_widx;
	assign op      = ir_q[31:26];
	assign fn      = ir_q[5:0];
	assign sh      = ir_q[10:6];
	assign rtf     = ir_q[20:16];
	assign rt      = ir_q[19:16];
	assign rd      = ir_q[14:11];
	assign imm     = ir_q[15:0];
	assign simm    = {{16{imm[15]}}, imm};
	assign ea      = rf_a + simm;
	assign ea_widx = ea[AW+1:2];
	assign br_tgt  = pc_q + {simm[PC_BITS-3:0], 2'b00};

	logic                is_mult, is_div;
	assign is_mult = (op == OP_SPECIAL) && (fn == FN_MULT);
	assign is_div  = (op == OP_SPECIAL) && (fn == FN_DIV);

	logic [XLEN-1:0]     ex_wval;
	logic                ex_we, ex_ill;
	logic [REG_BITS-1:0] ex_dst;
	logic [PC_BITS-1:0]  ex_npc;

	always_comb begin
		ex_wval = '0;
		ex_we   = 1'b0;
		ex_ill  = 1'b0;
		ex_dst  = rt;
		ex_npc  = pc_q + 20'd4;
		unique case (op)
			OP_SPECIAL: begin
				ex_dst = rd;
				ex_we  = 1'b1;
				unique case (fn)
					FN_SLL:  ex_wval = rf_b << sh;
					FN_SRL:  ex_wval = rf_b >> sh;
					FN_ADD:  ex_wval = rf_a + rf_b;
					FN_SUB:  ex_wval = rf_a - rf_b;
					FN_AND:  ex_wval = rf_a & rf_b;
					FN_OR:   ex_wval = rf_a | rf_b;
					FN_XOR:  ex_wval = rf_a ^ rf_b;
					FN_SLT:  ex_wval = XLEN'($signed(rf_a) < $signed(rf_b));
					FN_MULT, FN_DIV: ex_we = 1'b0;
					default: begin
						ex_we  = 1'b0;
						ex_ill = 1'b1;
					end
				endcase
			end
			OP_REGIMM: begin
				if (rtf == RT_BGEZ) begin
					if (!rf_a[XLEN-1]) begin
						ex_npc = br_tgt;
					end
				end else begin
					ex_ill = 1'b1;
				end
			end
			OP_J:    ex_npc = {ir_q[PC_BITS-3:0], 2'b00};
			OP_BEQ:  if (rf_a == rf_b) ex_npc = br_tgt;
			OP_BNE:  if (rf_a != rf_b) ex_npc = br_tgt;
			OP_BGTZ: if (rf_a != '0 && !rf_a[XLEN-1]) ex_npc = br_tgt;
			OP_ADDI: begin
				ex_we   = 1'b1;
				ex_wval = rf_a + simm;
			end
			OP_SLTI: begin
				ex_we   = 1'b1;
				ex_wval = XLEN'($signed(rf_a) < $signed(simm));
			end
			OP_ANDI: begin
				ex_we   = 1'b1;
				ex_wval = rf_a & {16'd0, imm};
			end
			OP_ORI: begin
				ex_we   = 1'b1;
				ex_wval = rf_a | {16'd0, imm};
			end
			OP_LUI: begin
				ex_we   = 1'b1;
				ex_wval = {imm, 16'd0};
			end
			OP_LB, OP_LW, OP_SB, OP_SW: ;
			default: ex_ill = 1'b1;
		endcase
	end

	// byte lane handling for lb and sb
	logic [7:0]      ld_byte;
	logic [XLEN-1:0] ld_val, sb_word;
	always_comb begin
		sb_word = mem_rdata;
		unique case (lane_q)
			2'd0: begin
				ld_byte       = mem_rdata[7:0];
				sb_word[7:0]  = b_q[7:0];
			end
			2'd1: begin
				ld_byte       = mem_rdata[15:8];
				sb_word[15:8] = b_q[7:0];
			end
			2'd2: begin
				ld_byte        = mem_rdata[23:16];
				sb_word[23:16] = b_q[7:0];
			end
			default: begin
				ld_byte        = mem_rdata[31:24];
				sb_word[31:24] = b_q[7:0];
			end
		endcase
		ld_val = (op == OP_LB) ? {{24{ld_byte[7]}}, ld_byte} : mem_rdata;
	end

	// memory, register file and divider requests
	always_comb begin
		mem_ctl   = '0;
		mem_addr  = fetch_widx;
		mem_wdata = rf_b;
		rf_ra     = reg_select;
		rf_rb     = mem_rdata[19:16];
		rf_wr     = '0;
		div_req   = '{start: 1'b0, dividend: rf_a, divisor: rf_b};
		unique case (state_q)
			ST_IDLE: begin
				if (accept && req_type == REQ_LOAD) begin
					mem_ctl   = '{en: 1'b1, we: 1'b1};
					mem_addr  = load_widx;
					mem_wdata = word_data;
				end else if (accept && req_type == REQ_STEP && !halt_q) begin
					mem_ctl = '{en: 1'b1, we: 1'b0};
				end
			end
			ST_DEC: begin
				rf_ra = mem_rdata[24:21];
			end
			ST_EXE: begin
				mem_addr = ea_widx;
				if (op == OP_LB || op == OP_LW || op == OP_SB) begin
					mem_ctl = '{en: 1'b1, we: 1'b0};
				end else if (op == OP_SW) begin
					mem_ctl = '{en: 1'b1, we: 1'b1};
				end
				if (ex_we) begin
					rf_wr = '{en: 1'b1, addr: ex_dst, data: ex_wval};
				end else if (is_div && rf_b == '0) begin
					rf_wr = '{en: 1'b1, addr: REG_HI, data: '1};
				end else if (is_div) begin
					div_req.start = 1'b1;
				end
			end
			ST_MUL: rf_wr = '{en: 1'b1, addr: REG_HI, data: prod_s1};
			ST_DIV: begin
				if (div_done) begin
					rf_wr = '{en: 1'b1, addr: REG_HI, data: div_q};
				end
			end
			ST_WB11: rf_wr = '{en: 1'b1, addr: REG_LO, data: r11_q};
			ST_MEM: begin
				mem_addr = widx_q;
				if (op == OP_SB) begin
					mem_ctl   = '{en: 1'b1, we: 1'b1};
					mem_wdata = sb_word;
				end else begin
					rf_wr = '{en: 1'b1, addr: rt, data: ld_val};
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			pc_q        <= '0;
			halt_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						res_ir_q  <= '0;
						res_val_q <= '0;
						res_wr_q  <= 1'b0;
						res_dst_q <= '0;
						res_ill_q <= 1'b0;
						res_dz_q  <= 1'b0;
						if (req_type == REQ_READ) begin
							state_q <= ST_RREAD;
						end else if (req_type == REQ_STEP && !halt_q) begin
							state_q <= ST_DEC;
						end else begin
							state_q <= ST_OUT;
						end
					end
				end
				ST_RREAD: begin
					res_val_q <= rf_a;
					state_q   <= ST_OUT;
				end
				ST_DEC: begin
					if (mem_rdata == '0) begin
						halt_q  <= 1'b1;
						state_q <= ST_OUT;
					end else begin
						ir_q     <= mem_rdata;
						res_ir_q <= mem_rdata;
						state_q  <= ST_EXE;
					end
				end
				ST_EXE: begin
					pc_q      <= ex_npc;
					res_ill_q <= ex_ill;
					b_q       <= rf_b;
					lane_q    <= ea[1:0];
					widx_q    <= ea_widx;
					prod_s1   <= rf_a * rf_b;
					r11_q     <= rf_a;
					if (ex_we) begin
						res_wr_q  <= 1'b1;
						res_dst_q <= ex_dst;
						res_val_q <= ex_wval;
					end
					if (op == OP_LB || op == OP_LW || op == OP_SB) begin
						state_q <= ST_MEM;
					end else if (is_mult) begin
						state_q <= ST_MUL;
					end else if (is_div && rf_b == '0) begin
						res_wr_q  <= 1'b1;
						res_dst_q <= REG_HI;
						res_val_q <= '1;
						res_dz_q  <= 1'b1;
						state_q   <= ST_WB11;
					end else if (is_div) begin
						state_q <= ST_DIV;
					end else begin
						state_q <= ST_OUT;
					end
				end
				ST_MUL: begin
					res_wr_q  <= 1'b1;
					res_dst_q <= REG_HI;
					res_val_q <= prod_s1;
					state_q   <= ST_OUT;
				end
				ST_DIV: begin
					if (div_done) begin
						res_wr_q  <= 1'b1;
						res_dst_q <= REG_HI;
						res_val_q <= div_q;
						r11_q     <= div_r;
						state_q   <= ST_WB11;
					end
				end
				ST_WB11: state_q <= ST_OUT;
				ST_MEM: begin
					if (op != OP_SB) begin
						res_wr_q  <= 1'b1;
						res_dst_q <= rt;
						res_val_q <= ld_val;
					end
					state_q <= ST_OUT;
				end
				ST_OUT: begin
					// hold while the previous result is still waiting
					if (out_load) begin
						pc_now         <= pc_q;
						fetched_word   <= res_ir_q;
						read_value     <= res_val_q;
						reg_written    <= res_wr_q;
						dest_reg       <= res_dst_q;
						halted         <= halt_q;
						illegal_op     <= res_ill_q;
						divide_by_zero <= res_dz_q;
						state_q        <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign out_valid = out_valid_q;

	mssu_word_mem #(
		.AW(AW)
	) u_mem (
		.clk   (clk),
		.arst_n(arst_n),
		.ctl   (mem_ctl),
		.addr  (mem_addr),
		.wdata (mem_wdata),
		.rdata (mem_rdata),
		.busy  (mem_busy)
	);

	mssu_regfile u_rf (
		.clk    (clk),
		.arst_n (arst_n),
		.ra     (rf_ra),
		.rb     (rf_rb),
		.rdata_a(rf_a),
		.rdata_b(rf_b),
		.wr     (rf_wr)
	);

	mssu_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (div_req),
		.done     (div_done),
		.quotient (div_q),
		.remainder(div_r)
	);

endmodule
`default_nettype wire

>>> sim/mssu_step_checker.sv
`default_nettype none
// -----------------------------------------------------------------------------
// mssu_step_checker
// Watches both channels of the instruction step unit. It keeps its own copy
// of the registers, the program counter, the halt flag and the word memory,
// works out the result of every accepted item, and compares each delivered
// result field by field with the oldest one still due.
// -----------------------------------------------------------------------------
module mssu_step_checker (
	input  wire               clk,
	input  wire               arst_n,
	input  wire               in_valid,
	input  wire               in_stall,
	input  wire  [1:0]        req_type,
	input  wire  [17:0]       word_addr,
	input  wire  [31:0]       word_data,
	input  wire  [3:0]        reg_select,
	input  wire               out_valid,
	input  wire               out_stall,
	input  wire  [19:0]       pc_now,
	input  wire  [31:0]       fetched_word,
	input  wire  [31:0]       read_value,
	input  wire               reg_written,
	input  wire  [3:0]        dest_reg,
	input  wire               halted,
	input  wire               illegal_op,
	input  wire               divide_by_zero,
	output int                fail_count,
	output int                pending_results
);
	import mssu_pkg::*;

	typedef struct packed {
		logic [19:0] pc;
		logic [31:0] word;
		logic [31:0] value;
		logic        wrote;
		logic [3:0]  dst;
		logic        halt;
		logic        illegal;
		logic        div_zero;
	} step_result_t;

	logic [31:0]  regs [NUM_REGS];
	logic [31:0]  mem [bit [17:0]];
	logic [19:0]  pc;
	logic         halt;
	step_result_t results_due [$];
	step_result_t got;
	step_result_t due;

	initial fail_count = 0;
	initial pending_results = 0;

	function automatic logic [31:0] mem_word(input logic [17:0] idx);
		return mem.exists(idx) ? mem[idx] : 32'd0;
	endfunction

	task automatic execute_request(input logic [1:0] rq, input logic [17:0] wa,
			input logic [31:0] wd, input logic [3:0] rsel, output step_result_t r);
		logic [31:0] ir, wval, a, b, simm, word, q, rem;
		logic signed [31:0] sa, sb;
		logic [3:0]  wreg, rs, rt, rd;
		logic [5:0]  op, fn;
		logic [4:0]  sh, rtf, lane;
		logic [15:0] imm;
		logic [19:0] ea, npc, target;
		logic [17:0] widx;
		logic        wrote, ill, dz;
		ir = '0; wval = '0; wreg = '0; wrote = 1'b0; ill = 1'b0; dz = 1'b0;
		if (rq == REQ_LOAD) begin
			mem[wa] = wd;
		end else if (rq == REQ_READ) begin
			wval = regs[rsel];
		end else if (rq == REQ_STEP && !halt) begin
			ir = mem_word(pc[19:2]);
			if (ir == 32'd0) begin
				halt = 1'b1;
			end else begin
				op = ir[31:26]; fn = ir[5:0]; sh = ir[10:6];
				rs = ir[24:21]; rt = ir[19:16]; rd = ir[14:11]; rtf = ir[20:16];
				a = regs[rs]; b = regs[rt];
				imm = ir[15:0];
				simm = {{16{imm[15]}}, imm};
				ea = 20'(a + simm);
				widx = ea[19:2];
				lane = {ea[1:0], 3'b000};
				npc = pc + 20'd4;
				target = pc + 20'(simm << 2);
				case (op)
				OP_SPECIAL: begin
					wreg = rd;
					wrote = 1'b1;
					case (fn)
					FN_SLL: wval = b << sh;
					FN_SRL: wval = b >> sh;
					FN_MULT: begin
						wreg = REG_HI;
						wval = a * b;
					end
					FN_DIV: begin
						dz = (b == 32'd0);
						sa = a;
						sb = b;
						if (dz) begin
							q = 32'hFFFF_FFFF;
							rem = a;
						end else if (a == 32'h8000_0000 && b == 32'hFFFF_FFFF) begin
							q = a;
							rem = '0;
						end else begin
							q = sa / sb;
							rem = sa % sb;
						end
						wreg = REG_HI;
						wval = q;
					end
					FN_ADD: wval = a + b;
					FN_SUB: wval = a - b;
					FN_AND: wval = a & b;
					FN_OR:  wval = a | b;
					FN_XOR: wval = a ^ b;
					FN_SLT: wval = {31'd0, $signed(a) < $signed(b)};
					default: begin
						ill = 1'b1;
						wrote = 1'b0;
						wreg = '0;
					end
					endcase
					if (fn == FN_DIV) begin
						regs[REG_HI] = q;
						regs[REG_LO] = rem;
					end else if (wrote) begin
						regs[wreg] = wval;
					end
				end
				OP_REGIMM: begin
					if (rtf == RT_BGEZ) begin
						if (!a[31]) npc = target;
					end else begin
						ill = 1'b1;
					end
				end
				OP_J:    npc = {ir[17:0], 2'b00};
				OP_BEQ:  if (a == b) npc = target;
				OP_BNE:  if (a != b) npc = target;
				OP_BGTZ: if (a != 32'd0 && !a[31]) npc = target;
				OP_ADDI: begin wval = a + simm; wrote = 1'b1; end
				OP_SLTI: begin wval = {31'd0, $signed(a) < $signed(simm)}; wrote = 1'b1; end
				OP_ANDI: begin wval = a & {16'd0, imm}; wrote = 1'b1; end
				OP_ORI:  begin wval = a | {16'd0, imm}; wrote = 1'b1; end
				OP_LUI:  begin wval = {imm, 16'd0}; wrote = 1'b1; end
				OP_LB: begin
					word = mem_word(widx) >> lane;
					wval = {{24{word[7]}}, word[7:0]};
					wrote = 1'b1;
				end
				OP_LW: begin wval = mem_word(widx); wrote = 1'b1; end
				OP_SB: begin
					word = mem_word(widx);
					mem[widx] = (word & ~(32'hFF << lane)) | ({24'd0, b[7:0]} << lane);
				end
				OP_SW: mem[widx] = b;
				default: ill = 1'b1;
				endcase
				if (op != OP_SPECIAL && wrote) begin
					wreg = rt;
					regs[rt] = wval;
				end
				pc = npc;
			end
		end
		if (rq == REQ_STEP && !wrote) begin
			wval = '0;
			wreg = '0;
		end
		r = '{pc, ir, wval, wrote, wreg, halt, ill, dz};
	endtask

	task automatic check_field(input string what, input logic [31:0] exp_val,
			input logic [31:0] act_val);
		if (exp_val !== act_val) begin
			$display("%0t: %s mismatch, expected %h, actual %h", $time, what, exp_val, act_val);
			fail_count++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			foreach (regs[i]) regs[i] = '0;
			mem.delete();
			pc = '0;
			halt = 1'b0;
			results_due.delete();
		end else begin
			// compare first so that an item taken at this edge never pairs with its own result
			if (out_valid && !out_stall) begin
				got = '{pc_now, fetched_word, read_value, reg_written, dest_reg, halted,
					illegal_op, divide_by_zero};
				if (results_due.size() == 0) begin
					$display("%0t: unexpected result, expected none, actual %h", $time, got);
					fail_count++;
				end else begin
					due = results_due.pop_front();
					check_field("pc_now", due.pc, got.pc);
					check_field("fetched_word", due.word, got.word);
					check_field("read_value", due.value, got.value);
					check_field("reg_written", due.wrote, got.wrote);
					check_field("dest_reg", due.dst, got.dst);
					check_field("halted", due.halt, got.halt);
					check_field("illegal_op", due.illegal, got.illegal);
					check_field("divide_by_zero", due.div_zero, got.div_zero);
				end
			end
			if (in_valid && !in_stall) begin
				execute_request(req_type, word_addr, word_data, reg_select, due);
				results_due.push_back(due);
			end
		end
		pending_results = results_due.size();
	end

endmodule
`default_nettype wire

>>> sim/mips_subset_instruction_step_unit_test.sv
`default_nettype none
// -----------------------------------------------------------------------------
// mips_subset_instruction_step_unit_test
// Runs a short directed program through the step unit (division corner cases,
// shifts, byte access, illegal codes), then random programs kept inside a
// fully loaded code region mixed with loads and register reads, and finally
// forces a halt. Both channels idle at random.
// -----------------------------------------------------------------------------
module mips_subset_instruction_step_unit_test;
	import mssu_pkg::*;

	localparam int CYCLE_LIMIT = 2_000_000;
	localparam int CODE_WORDS  = 128;
	localparam logic [5:0] OP_BAD     = 6'h3F;
	localparam logic [5:0] OP_XORI    = 6'h0E;
	localparam logic [5:0] FN_SYSCALL = 6'h0C;
	localparam logic [4:0] RT_BLTZ    = 5'd0;
	localparam logic [4:0] R_BASE     = 5'd15;

	logic               clk;
	logic               arst_n = 1'b0;
	logic               in_valid = 1'b0;
	logic               in_stall;
	logic [1:0]         req_type = REQ_LOAD;
	logic [17:0]        word_addr = '0;
	logic [31:0]        word_data = '0;
	logic [3:0]         reg_select = '0;
	logic               out_valid;
	logic               out_stall = 1'b0;
	logic [19:0]        pc_now;
	logic [31:0]        fetched_word;
	logic signed [31:0] read_value;
	logic               reg_written;
	logic [3:0]         dest_reg;
	logic               halted;
	logic               illegal_op;
	logic               divide_by_zero;
	int                 fail_count;
	int                 pending_results;

	logic        quiet = 1'b0;
	int          sent_count = 0;
	int          done_count = 0;
	int          cycle_count = 0;
	int          stall_left = 0;
	logic [19:0] last_pc = '0;
	logic [31:0] boot_code [16];

	mips_subset_instruction_step_unit i_dut (.*);
	mssu_step_checker i_checker (.*);

	always begin
		clk = 1'b1;
		#2;
		clk = 1'b0;
		#2;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("status: fail");
			$finish;
		end
	end

	// track the program counter so that steps stay inside the loaded code
	always @(posedge clk) begin
		if (out_valid && !out_stall) begin
			done_count <= done_count + 1;
			last_pc <= pc_now;
		end
	end

	always @(negedge clk) begin
		if (stall_left != 0) begin
			stall_left <= stall_left - 1;
		end else if (!quiet && $urandom_range(0, 6) == 0) begin
			out_stall <= 1'b1;
			stall_left <= $urandom_range(0, 17);
		end else begin
			out_stall <= 1'b0;
		end
	end

	function automatic logic [31:0] enc_r(input logic [5:0] fn, input logic [4:0] rs,
			input logic [4:0] rt, input logic [4:0] rd, input logic [4:0] sh);
		return {OP_SPECIAL, rs, rt, rd, sh, fn};
	endfunction

	function automatic logic [31:0] enc_i(input logic [5:0] op, input logic [4:0] rs,
			input logic [4:0] rt, input logic [15:0] imm);
		return {op, rs, rt, imm};
	endfunction

	function automatic logic [31:0] jump_to_middle();
		return {OP_J, 8'($urandom), 18'($urandom_range(32, 95))};
	endfunction

	// random instruction: never zero, never writes r14 or r15, stores go off r15
	function automatic logic [31:0] random_instruction();
		logic [31:0] ir;
		logic [4:0]  src1, src2, dst;
		logic [15:0] imm, off;
		logic [5:0]  alu_fn [6];
		logic [5:0]  imm_op [5];
		alu_fn = '{FN_ADD, FN_SUB, FN_AND, FN_OR, FN_XOR, FN_SLT};
		imm_op = '{OP_ADDI, OP_SLTI, OP_ANDI, OP_ORI, OP_LUI};
		do begin
			src1 = 5'($urandom);
			src2 = 5'($urandom);
			dst = {1'($urandom), 4'($urandom_range(0, 13))};
			imm = ($urandom_range(0, 3) == 0) ? {16{1'($urandom)}} ^ 16'h7FFF : 16'($urandom);
			off = 16'($urandom_range(1, 6));
			if ($urandom_range(0, 1) == 1) off = -off;
			case ($urandom_range(0, 19))
			0:  ir = enc_r(FN_SLL, src1, src2, dst, 5'($urandom));
			1:  ir = enc_r(FN_SRL, src1, src2, dst, 5'($urandom));
			2:  ir = enc_r(FN_MULT, src1, src2, 5'($urandom), 5'd0);
			3:  ir = enc_r(FN_DIV, src1, ($urandom_range(0, 3) == 0) ? 5'd0 : src2,
				5'($urandom), 5'd0);
			4, 5, 6, 7, 8, 9:
				ir = enc_r(alu_fn[$urandom_range(0, 5)], src1, src2, dst, 5'd0);
			10: ir = enc_r(($urandom_range(0, 1) == 1) ? FN_SYSCALL : OP_BAD, src1, src2, dst,
				5'd0);
			11: ir = enc_i(imm_op[$urandom_range(0, 4)], src1, dst, imm);
			12: ir = enc_i(($urandom_range(0, 1) == 1) ? OP_BEQ : OP_BNE, src1, src2, off);
			13: ir = enc_i(OP_BGTZ, src1, src2, off);
			14: ir = enc_i(OP_REGIMM, src1, ($urandom_range(0, 3) == 0) ? RT_BLTZ : RT_BGEZ,
				off);
			15: ir = jump_to_middle();
			16, 17: ir = enc_i(($urandom_range(0, 1) == 1) ? OP_LW : OP_LB, src1, dst, imm);
			18: ir = enc_i(($urandom_range(0, 1) == 1) ? OP_SW : OP_SB, R_BASE, src2, imm);
			default: ir = enc_i(($urandom_range(0, 1) == 1) ? OP_XORI : OP_BAD, src1, src2, imm);
			endcase
		end while (ir == 32'd0);
		return ir;
	endfunction

	// called at a falling edge; leaves valid high for the caller's next item
	task automatic send_item(input logic [1:0] rq, input logic [17:0] wa,
			input logic [31:0] wd, input logic [3:0] rsel);
		if (!quiet && $urandom_range(0, 5) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 18)) @(negedge clk);
		end
		in_valid <= 1'b1;
		req_type <= rq;
		word_addr <= wa;
		word_data <= wd;
		reg_select <= rsel;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		sent_count++;
		@(negedge clk);
	endtask

	task automatic drain();
		while (sent_count != done_count) @(negedge clk);
	endtask

	task automatic step_in_code();
		logic [17:0] w;
		while (sent_count - done_count > 1) @(negedge clk);
		w = last_pc[19:2];
		if (w < 24 || w > 103) begin
			drain();
			w = last_pc[19:2];
			if (w < 24 || w > 103)
				send_item(REQ_LOAD, w, jump_to_middle(), 4'($urandom));
		end
		send_item(REQ_STEP, 18'($urandom), $urandom, 4'($urandom));
	endtask

	initial begin
		int          k;
		logic [17:0] w;
		logic [31:0] d;
		boot_code[0]  = enc_i(OP_LUI, 5'd0, R_BASE, 16'h0002);
		boot_code[1]  = enc_i(OP_ADDI, 5'd0, 5'd1, 16'hFFFF);
		boot_code[2]  = enc_i(OP_LUI, 5'd0, 5'd2, 16'h8000);
		boot_code[3]  = enc_r(FN_DIV, 5'd2, 5'd1, 5'd0, 5'd0);   // most negative over minus one
		boot_code[4]  = enc_r(FN_DIV, 5'd1, 5'd0, 5'd0, 5'd0);   // zero divisor
		boot_code[5]  = enc_r(FN_MULT, 5'd2, 5'd1, 5'd0, 5'd0);
		boot_code[6]  = enc_r(FN_SRL, 5'd0, 5'd2, 5'd3, 5'd31);
		boot_code[7]  = enc_i(OP_ANDI, 5'd1, 5'd5, 16'hFFFF);
		boot_code[8]  = enc_i(OP_SB, R_BASE, 5'd1, 16'h0003);
		boot_code[9]  = enc_i(OP_LB, R_BASE, 5'd9, 16'h0003);
		boot_code[10] = enc_i(OP_LW, R_BASE, 5'd12, 16'h0001);   // unaligned word read
		boot_code[11] = {OP_BAD, 26'h1};
		boot_code[12] = enc_r(FN_SYSCALL, 5'd1, 5'd0, 5'd0, 5'd0);
		boot_code[13] = enc_i(OP_REGIMM, 5'd1, RT_BLTZ, 16'h0004);
		boot_code[14] = enc_r(FN_SLT, 5'd1, 5'd0, 5'd8, 5'd0);
		boot_code[15] = {OP_J, 8'hFF, 18'd40};                   // target wraps the pc
		repeat (4) @(negedge clk);
		arst_n <= 1'b1;

		foreach (boot_code[i]) send_item(REQ_LOAD, 18'(i), boot_code[i], 4'($urandom));
		repeat (16) send_item(REQ_STEP, 18'($urandom), $urandom, 4'($urandom));
		send_item(REQ_LOAD, 18'h3FFFF, 32'hFFFF_FFFF, 4'hF);
		send_item(REQ_LOAD, 18'd1000, 32'd0, 4'h0);
		send_item(REQ_READ, 18'h3FFFF, 32'hFFFF_FFFF, 4'd10);
		send_item(REQ_READ, 18'd0, 32'd0, 4'd11);
		send_item(REQ_READ, 18'd0, 32'd0, 4'd15);

		// fill the rest of the code region before stepping on
		for (int i = 16; i < CODE_WORDS; i++)
			send_item(REQ_LOAD, 18'(i), random_instruction(), 4'($urandom));

		for (int i = 0; i < 1000; i++) begin
			quiet = (i >= 850);
			if (i == 500) drain();
			k = $urandom_range(0, 19);
			if (k < 11) begin
				step_in_code();
			end else if (k < 14) begin
				send_item(REQ_LOAD, 18'($urandom_range(0, CODE_WORDS - 1)), random_instruction(),
					4'($urandom));
			end else if (k < 16) begin
				w = 18'($urandom_range(256, 262143));
				d = ($urandom_range(0, 3) == 0) ? 32'($urandom_range(0, 255)) : $urandom;
				send_item(REQ_LOAD, w, d, 4'($urandom));
			end else begin
				send_item(REQ_READ, 18'($urandom), $urandom, 4'($urandom));
			end
		end

		// jump to an empty word, halt there, then poke the halted unit
		drain();
		send_item(REQ_LOAD, last_pc[19:2], {OP_J, 26'd200}, 4'h0);
		repeat (3) send_item(REQ_STEP, 18'($urandom), $urandom, 4'($urandom));
		send_item(REQ_LOAD, 18'd5, random_instruction(), 4'h0);
		send_item(REQ_READ, 18'd0, 32'd0, 4'd15);
		send_item(REQ_STEP, 18'($urandom), $urandom, 4'($urandom));
		in_valid <= 1'b0;

		while (pending_results != 0) @(negedge clk);
		repeat (50) @(posedge clk);
		if (fail_count == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
`default_nettype wire
